FILE: rtl/core/ps2mt_pkg.sv
// ps2mt_pkg: shared types and constants for the ps2 mouse packet tracker
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package ps2mt_pkg;

  // fixed field widths
  localparam int BYTE_BITS   = 8;
  localparam int LIMIT_BITS  = 12;
  localparam int OUT_BITS    = 12;
  localparam int BTN_BITS    = 3;
  localparam int COUNT_BITS  = 32;
  localparam int DELTA_BITS  = 9;
  localparam int CFG_IDX_BITS = 2;

  // flag byte layout
  localparam int SYNC_BIT    = 3;
  localparam int X_SIGN_BIT  = 4;
  localparam int Y_SIGN_BIT  = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_LIMIT = 2'd1;

  // reset values
  localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = 12'd799;
  localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = 12'd599;
  localparam int POS_X_RESET = 400;
  localparam int POS_Y_RESET = 300;

  // position within a 3-byte packet
  typedef enum logic [2:0] {
    SLOT_FLAG = 3'b001,
    SLOT_X    = 3'b010,
    SLOT_Y    = 3'b100
  } slot_t;

  // decoded view of the word currently in the framer
  typedef struct packed {
    logic                          emits;    // word completes a packet
    logic [BTN_BITS-1:0]           buttons;
    logic signed [DELTA_BITS-1:0]  dx;
    logic signed [DELTA_BITS-1:0]  dy;
  } pkt_t;

endpackage

FILE: rtl/core/ps2_mouse_packet_tracker.sv
// ps2_mouse_packet_tracker: top level, input register, cursor state and result register
// depends on ps2mt_pkg, ps2mt_framer, ps2mt_axis
`timescale 1ns / 1ps

// Takes raw PS/2 mouse bytes, one word per handshake on the in channel, and
// frames them into 3-byte packets (flag, X move, Y move). A word offered as
// the first of a packet is dropped unless its bit 3 is set. Each completed
// packet produces one word on the out channel with the clamped cursor
// position (Y inverted to screen orientation), the three button bits, the
// packet count and the raw byte count (both including this word, wrapping
// at 2^32). Dropped and partial-packet bytes produce nothing but still count.
// Rate: one input word per cycle sustained; each word sits in the input
// register, where framing, the cursor add and the clamp run, and a completed
// packet then moves into the output register, which raises out_valid. Only
// the output register can stall the input side, and only for words that
// complete a packet.
// Configuration: cfg index 0 writes x_limit, index 1 writes y_limit, other
// indexes are ignored; cfg_ready is always high. Limits take effect at the
// next completed packet. Reset puts the cursor at (400, 300), saturated to
// the coordinate range set by COORD_BITS.

module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  // raw byte channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BYTE_BITS-1:0]    data_byte,
  // packet result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BITS-1:0]     cursor_x,
  output logic [OUT_BITS-1:0]     cursor_y,
  output logic [BTN_BITS-1:0]     button_bits,
  output logic [COUNT_BITS-1:0]   packets_done,
  output logic [COUNT_BITS-1:0]   bytes_seen,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LIMIT_BITS-1:0]   cfg_data
);

  // width wide enough for both the coordinate and the 12-bit result field
  localparam int WW = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam logic [COORD_BITS-1:0] X_RESET =
    COORD_BITS'((POS_X_RESET > COORD_MAX) ? COORD_MAX : POS_X_RESET);
  localparam logic [COORD_BITS-1:0] Y_RESET =
    COORD_BITS'((POS_Y_RESET > COORD_MAX) ? COORD_MAX : POS_Y_RESET);

  // config registers
  logic [LIMIT_BITS-1:0] x_limit;
  logic [LIMIT_BITS-1:0] y_limit;

  // input register stage
  logic                  s1_valid;
  logic [BYTE_BITS-1:0]  s1_byte;
  logic                  s1_fire;
  logic                  out_free;

  // tracked state
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [COUNT_BITS-1:0] packet_counter;
  logic [COUNT_BITS-1:0] packet_counter_next;
  logic [COUNT_BITS-1:0] byte_counter;
  logic [COUNT_BITS-1:0] byte_counter_next;
  logic [WW-1:0]         pos_x_wide;
  logic [WW-1:0]         pos_y_wide;

  pkt_t                  pkt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= X_LIMIT_RESET;
      y_limit <= Y_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_LIMIT: x_limit <= cfg_data;
        REG_Y_LIMIT: y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // a word leaves the input register unless it completes a packet while
  // the output register is still full
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && (out_free || !pkt.emits);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  // framing
  ps2mt_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .word_valid (s1_valid),
    .word_fire  (s1_fire),
    .word_byte  (s1_byte),
    .pkt        (pkt)
  );

  // cursor update, Y subtracted since ps2 Y points up
  ps2mt_axis #(.COORD_BITS(COORD_BITS), .INVERT(1'b0)) u_axis_x (
    .pos      (pos_x),
    .delta    (pkt.dx),
    .limit    (x_limit),
    .pos_next (pos_x_next)
  );

  ps2mt_axis #(.COORD_BITS(COORD_BITS), .INVERT(1'b1)) u_axis_y (
    .pos      (pos_y),
    .delta    (pkt.dy),
    .limit    (y_limit),
    .pos_next (pos_y_next)
  );

  assign byte_counter_next   = byte_counter + 1'b1;
  assign packet_counter_next = packet_counter + 1'b1;
  assign pos_x_wide          = WW'(pos_x_next);
  assign pos_y_wide          = WW'(pos_y_next);

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x          <= X_RESET;
      pos_y          <= Y_RESET;
      packet_counter <= '0;
      byte_counter   <= '0;
    end else if (s1_fire) begin
      byte_counter <= byte_counter_next;
      if (pkt.emits) begin
        pos_x          <= pos_x_next;
        pos_y          <= pos_y_next;
        packet_counter <= packet_counter_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && pkt.emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && pkt.emits) begin
      cursor_x     <= pos_x_wide[OUT_BITS-1:0];
      cursor_y     <= pos_y_wide[OUT_BITS-1:0];
      button_bits  <= pkt.buttons;
      packets_done <= packet_counter_next;
      bytes_seen   <= byte_counter_next;
    end
  end

endmodule

FILE: rtl/core/ps2mt_framer.sv
// ps2mt_framer: 3-byte packet framing with bit-3 resync
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_framer
  import ps2mt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  input  logic                 word_fire,
  input  logic [BYTE_BITS-1:0] word_byte,
  output pkt_t                 pkt
);

  slot_t                slot;
  slot_t                slot_next;
  logic [BYTE_BITS-1:0] flag_byte;
  logic [BYTE_BITS-1:0] flag_byte_next;
  logic [BYTE_BITS-1:0] move_x_byte;
  logic [BYTE_BITS-1:0] move_x_byte_next;

  always_comb begin
    slot_next        = slot;
    flag_byte_next   = flag_byte;
    move_x_byte_next = move_x_byte;
    pkt.emits        = 1'b0;
    case (slot)
      SLOT_FLAG: begin
        if (word_byte[SYNC_BIT]) begin
          flag_byte_next = word_byte;
          slot_next      = SLOT_X;
        end
      end
      SLOT_X: begin
        move_x_byte_next = word_byte;
        slot_next        = SLOT_Y;
      end
      default: begin
        // third byte closes the packet
        pkt.emits = word_valid;
        slot_next = SLOT_FLAG;
      end
    endcase
    pkt.buttons = flag_byte[BTN_BITS-1:0];
    pkt.dx      = {flag_byte[X_SIGN_BIT], move_x_byte};
    pkt.dy      = {flag_byte[Y_SIGN_BIT], word_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= SLOT_FLAG;
      flag_byte   <= '0;
      move_x_byte <= '0;
    end else if (word_fire) begin
      slot        <= slot_next;
      flag_byte   <= flag_byte_next;
      move_x_byte <= move_x_byte_next;
    end
  end

endmodule

FILE: rtl/core/ps2mt_axis.sv
// ps2mt_axis: one cursor axis, adds (or, with INVERT, subtracts) a signed move and clamps to [0, limit]
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_axis
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter bit INVERT     = 1'b0
) (
  input  logic [COORD_BITS-1:0]        pos,
  input  logic signed [DELTA_BITS-1:0] delta,
  input  logic [LIMIT_BITS-1:0]        limit,
  output logic [COORD_BITS-1:0]        pos_next
);

  localparam int SW = COORD_BITS + 2;
  localparam int LW = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
  localparam logic [LW-1:0] COORD_MAX = LW'((64'd1 << COORD_BITS) - 64'd1);

  logic signed [SW-1:0]   pos_ext;
  logic signed [SW-1:0]   delta_ext;
  logic signed [SW-1:0]   sum;
  logic [LW-1:0]          limit_ext;
  logic [COORD_BITS-1:0]  lim;
  logic signed [SW-1:0]   lim_ext;

  always_comb begin
    pos_ext   = $signed({2'b00, pos});
    delta_ext = {{(SW-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
    sum       = INVERT ? (pos_ext - delta_ext) : (pos_ext + delta_ext);
    // limit saturates at the coordinate range
    limit_ext = LW'(limit);
    lim       = (limit_ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                        : limit_ext[COORD_BITS-1:0];
    lim_ext   = $signed({2'b00, lim});
    if (sum < 0) begin
      pos_next = '0;
    end else if (sum > lim_ext) begin
      pos_next = lim;
    end else begin
      pos_next = sum[COORD_BITS-1:0];
    end
  end

endmodule
